/* sv/tsi_pkg.sv */
// ----------------------------------------------------------------------------
// tsi_pkg: shared types and constants
// Buffer word layout, header codes, result width and register map of the
// TDC start/stop interval extractor.
// ----------------------------------------------------------------------------
package tsi_pkg;

  // buffer word layout
  localparam int WORD_W  = 32;
  localparam int HDR_W   = 5;
  localparam int HDR_LSB = 27;
  localparam int CH_W    = 5;
  localparam int CH_LSB  = 21;

  // header codes
  localparam logic [HDR_W-1:0] HDR_GLOBAL = 5'h08;
  localparam logic [HDR_W-1:0] HDR_TDC    = 5'h01;
  localparam logic [HDR_W-1:0] HDR_MEAS   = 5'h00;

  // result width and saturation limits
  localparam int OUT_W   = 27;
  localparam int OUT_MAX = 67108863;
  localparam int OUT_MIN = -67108864;

  // configuration register map, decoded on paddr[2]
  localparam int          PADDR_W   = 3;
  localparam int          PDATA_W   = 32;
  localparam logic        REG_START = 1'b0;
  localparam logic        REG_STOP  = 1'b1;
  localparam logic [CH_W-1:0] START_CH_RST = 5'd0;
  localparam logic [CH_W-1:0] STOP_CH_RST  = 5'd1;

  // event parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_TDC  = 3'b010,
    PH_MEAS = 3'b100
  } phase_t;

  // queue status seen by the back part
  typedef struct packed {
    logic rec_valid;
    logic res_full;
  } back_stat_t;

endpackage

/* sv/tsi_queue.sv */
// ----------------------------------------------------------------------------
// tsi_queue: small first-in first-out buffer
// Register-based queue with a head read on the data port while not empty.
// ----------------------------------------------------------------------------
module tsi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // store the incoming beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/tsi_front.sv */
// ----------------------------------------------------------------------------
// tsi_front: buffer word parser
// Walks the global header / TDC header / measurement framing, latches the
// start and stop hits and hands a finished event to the back part.
// ----------------------------------------------------------------------------
module tsi_front
  import tsi_pkg::*;
#(
  parameter int TIME_BITS = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [WORD_W-1:0]    word,
  input  logic [CH_W-1:0]      start_channel,
  input  logic [CH_W-1:0]      stop_channel,
  output logic                 rec_push,
  output logic [TIME_BITS-1:0] rec_start,
  output logic [TIME_BITS-1:0] rec_stop
);

  phase_t               phase;
  phase_t               phase_next;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] stop_time;
  logic [1:0]           hit_count;
  logic                 start_seen;
  logic                 stop_seen;
  logic [HDR_W-1:0]     hdr;
  logic [CH_W-1:0]      ch;
  logic [TIME_BITS-1:0] t;
  logic                 is_meas;
  logic                 start_hit;
  logic                 stop_hit;

  assign hdr       = word[HDR_LSB +: HDR_W];
  assign ch        = word[CH_LSB +: CH_W];
  assign t         = word[TIME_BITS-1:0];
  assign is_meas   = accept && (phase == PH_MEAS) && (hdr == HDR_MEAS);
  assign start_hit = is_meas && (ch == start_channel);
  assign stop_hit  = is_meas && (ch == stop_channel);

  // close the event on the first non-measurement word
  assign rec_push  = accept && (phase == PH_MEAS) && (hdr != HDR_MEAS)
                     && (hit_count == 2'd2) && start_seen && stop_seen;
  assign rec_start = start_time;
  assign rec_stop  = stop_time;

  // choose the next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_TDC: begin
        phase_next = (hdr == HDR_TDC) ? PH_MEAS : PH_IDLE;
      end
      PH_MEAS: begin
        phase_next = (hdr == HDR_MEAS) ? PH_MEAS : PH_IDLE;
      end
      default: begin
        phase_next = (hdr == HDR_GLOBAL) ? PH_TDC : PH_IDLE;
      end
    endcase
  end

  // advance the phase and the hit bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hit_count  <= '0;
      start_seen <= 1'b0;
      stop_seen  <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_TDC && hdr == HDR_TDC) begin
        hit_count  <= '0;
        start_seen <= 1'b0;
        stop_seen  <= 1'b0;
      end else begin
        if (start_hit) begin
          start_seen <= 1'b1;
        end
        if (stop_hit) begin
          stop_seen <= 1'b1;
        end
        if ((start_hit || stop_hit) && hit_count != 2'd3) begin
          hit_count <= hit_count + 1'b1;
        end
      end
    end
  end

  // latch hit times, a later hit overwrites
  always_ff @(posedge clk) begin
    if (start_hit) begin
      start_time <= t;
    end
    if (stop_hit) begin
      stop_time <= t;
    end
  end

endmodule

/* sv/tsi_back.sv */
// ----------------------------------------------------------------------------
// tsi_back: interval arithmetic
// Two-stage pipeline: subtract start from stop, then scale, saturate and
// hand the result to the output queue.
// ----------------------------------------------------------------------------
module tsi_back
  import tsi_pkg::*;
#(
  parameter int TIME_BITS  = 21,
  parameter int TIME_SCALE = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  back_stat_t              stat,
  input  logic [TIME_BITS-1:0]    rec_start,
  input  logic [TIME_BITS-1:0]    rec_stop,
  output logic                    rec_pop,
  output logic                    res_push,
  output logic signed [OUT_W-1:0] res_value
);

  localparam int DIFF_W  = TIME_BITS + 1;
  localparam int SCALE_W = $clog2(TIME_SCALE + 1);
  localparam int RAW_W   = DIFF_W + SCALE_W + 1;
  localparam int PROD_W  = (RAW_W > OUT_W + 1) ? RAW_W : OUT_W + 1;
  localparam logic signed [PROD_W-1:0] SCALE_S = PROD_W'(TIME_SCALE);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(OUT_MAX);
  localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(OUT_MIN);

  logic                     s1_valid;
  logic signed [DIFF_W-1:0] s1_diff;
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_prod;
  logic                     s1_move;

  // stage handshakes
  assign res_push = s2_valid && !stat.res_full;
  assign s1_move  = s1_valid && (!s2_valid || res_push);
  assign rec_pop  = stat.rec_valid && (!s1_valid || s1_move);

  // hold valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (rec_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (res_push) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // subtract, then scale
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_diff <= signed'({1'b0, rec_stop}) - signed'({1'b0, rec_start});
    end
    if (s1_move) begin
      s2_prod <= PROD_W'(s1_diff) * SCALE_S;
    end
  end

  // clamp to the result range
  always_comb begin
    if (s2_prod > SAT_MAX) begin
      res_value = OUT_W'(SAT_MAX);
    end else if (s2_prod < SAT_MIN) begin
      res_value = OUT_W'(SAT_MIN);
    end else begin
      res_value = s2_prod[OUT_W-1:0];
    end
  end

endmodule

/* sv/tdc_event_start_stop_interval.sv */
// ----------------------------------------------------------------------------
// tdc_event_start_stop_interval: TDC start/stop interval extractor
// Parses TDC output buffer events and emits (stop - start) * TIME_SCALE for
// events that hold exactly two hits covering both the start and stop channel.
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------
//   words in  | push / full          | buffer_word [31:0]
//   results   | pop / empty          | interval signed [26:0]
//   config    | APB psel/penable/... | start_channel, stop_channel
//
// One buffer word is taken every cycle while full is low; the parser does a
// header compare and a latch update per word.
// The edge that takes the closing word writes the event queue; the result
// then passes the subtract stage, the scale stage and the result queue, in
// that order, before empty drops; a full result queue holds it back.
// full is high only while the event queue between parser and arithmetic is
// full, which happens when results are not popped.
// Reset is synchronous; all queues come up empty and the parser idle.
// ----------------------------------------------------------------------------
module tdc_event_start_stop_interval
  import tsi_pkg::*;
#(
  parameter int TIME_BITS  = 21,
  parameter int TIME_SCALE = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic [WORD_W-1:0]       buffer_word,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [OUT_W-1:0] interval
);

  localparam int EVQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  logic [CH_W-1:0]         start_channel;
  logic [CH_W-1:0]         stop_channel;
  logic                    accept;
  logic                    rec_push;
  logic [TIME_BITS-1:0]    rec_start;
  logic [TIME_BITS-1:0]    rec_stop;
  logic [TIME_BITS-1:0]    q_start;
  logic [TIME_BITS-1:0]    q_stop;
  logic                    evq_empty;
  logic                    rec_pop;
  logic                    res_push;
  logic                    res_full;
  logic signed [OUT_W-1:0] res_value;
  logic [OUT_W-1:0]        res_bits;
  back_stat_t              stat;

  assign pready = 1'b1;
  assign accept = push && !full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_channel <= START_CH_RST;
      stop_channel  <= STOP_CH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_START: start_channel <= pwdata[CH_W-1:0];
        REG_STOP:  stop_channel  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[2])
      REG_START: prdata = PDATA_W'(start_channel);
      REG_STOP:  prdata = PDATA_W'(stop_channel);
      default:   prdata = '0;
    endcase
  end

  // parser
  tsi_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .word          (buffer_word),
    .start_channel (start_channel),
    .stop_channel  (stop_channel),
    .rec_push      (rec_push),
    .rec_start     (rec_start),
    .rec_stop      (rec_stop)
  );

  // event queue between parser and arithmetic
  tsi_queue #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata ({rec_stop, rec_start}),
    .full  (full),
    .pop   (rec_pop),
    .rdata ({q_stop, q_start}),
    .empty (evq_empty)
  );

  assign stat.rec_valid = !evq_empty;
  assign stat.res_full  = res_full;

  // arithmetic
  tsi_back #(
    .TIME_BITS  (TIME_BITS),
    .TIME_SCALE (TIME_SCALE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .rec_start (q_start),
    .rec_stop  (q_stop),
    .rec_pop   (rec_pop),
    .res_push  (res_push),
    .res_value (res_value)
  );

  // result queue
  tsi_queue #(
    .WIDTH (OUT_W),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_value),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign interval = signed'(res_bits);

  // parser never closes an event into a full event queue
  a_evq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> !full)
    else $error("event beat pushed into full event queue");

  // arithmetic only draws from a non-empty event queue
  a_evq_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rec_pop |-> !evq_empty)
    else $error("event beat popped from empty event queue");

  // arithmetic only hands over when the result queue has room
  a_resq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into full result queue");

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && evq_empty)
    else $error("queues not empty after reset");

endmodule

/* tb/tdc_event_start_stop_interval_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_event_start_stop_interval_test: self-checking bench for the TDC
// start/stop interval extractor
// Feeds output buffer words through the push/full port, keeps its own parser
// model in step with every accepted word, and checks every popped interval
// against the queue of predicted intervals. The run starts with a table of
// directed words and then moves on to random events under several channel
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tdc_event_start_stop_interval_test;
  import tsi_pkg::*;

  localparam int TBITS      = 21;
  localparam int SCALE      = 25;
  localparam int N_DIRECTED = 26;
  localparam int N_PHASES   = 5;
  localparam int PHASE_BEATS = 200;
  localparam int SETTLE     = 10;
  localparam int LONG_HOLD  = 400;
  localparam int TIMEOUT_NS = 2_400_000;

  typedef struct {
    logic [WORD_W-1:0]       word;
    bit                      known;
    logic signed [OUT_W-1:0] interval;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    push;
  logic                    full;
  logic [WORD_W-1:0]       buffer_word;
  logic                    empty;
  logic                    pop;
  logic signed [OUT_W-1:0] interval;

  // parser model state and channel settings
  phase_t           ph;
  logic [TBITS-1:0] start_t;
  logic [TBITS-1:0] stop_t;
  logic [1:0]       hits;
  bit               start_seen;
  bit               stop_seen;
  logic [CH_W-1:0]  cfg_start;
  logic [CH_W-1:0]  cfg_stop;

  logic signed [OUT_W-1:0] interval_q[$];
  dir_row_t dir_rows[N_DIRECTED];

  int n_words;
  int n_intervals;
  int n_errors;
  int n_settings;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  tdc_event_start_stop_interval #(
    .TIME_BITS (TBITS),
    .TIME_SCALE(SCALE)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .buffer_word(buffer_word),
    .empty      (empty),
    .pop        (pop),
    .interval   (interval)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL tdc_event_start_stop_interval");
    $finish;
  end

  function automatic logic [WORD_W-1:0] meas_word(logic [CH_W-1:0] ch, logic [TBITS-1:0] t);
    return {HDR_MEAS, 1'b0, ch, t};
  endfunction

  function automatic logic [WORD_W-1:0] hdr_word(logic [HDR_W-1:0] hdr,
                                                 logic [WORD_W-HDR_W-1:0] rest);
    return {hdr, rest};
  endfunction

  // Append one predicted interval to the tail of the queue.
  task automatic expect_interval(input logic signed [OUT_W-1:0] val);
    interval_q = {interval_q, val};
  endtask

  // Advance the parser model by one accepted word; flag an interval if the
  // word closes an event with exactly two hits covering both channels.
  task automatic parse_word(input logic [WORD_W-1:0] w, output bit got,
                            output logic signed [OUT_W-1:0] val);
    logic [HDR_W-1:0] hdr;
    logic [CH_W-1:0]  ch;
    logic [TBITS-1:0] t;
    bit               hit;
    longint           v;
    hdr = w[HDR_LSB +: HDR_W];
    ch  = w[CH_LSB +: CH_W];
    t   = w[TBITS-1:0];
    got = 1'b0;
    val = '0;
    case (ph)
      PH_TDC: begin
        if (hdr == HDR_TDC) begin
          ph         = PH_MEAS;
          hits       = 2'd0;
          start_seen = 1'b0;
          stop_seen  = 1'b0;
        end else begin
          ph = PH_IDLE;
        end
      end
      PH_MEAS: begin
        if (hdr == HDR_MEAS) begin
          hit = 1'b0;
          if (ch == cfg_start) begin
            start_t    = t;
            start_seen = 1'b1;
            hit        = 1'b1;
          end
          if (ch == cfg_stop) begin
            stop_t    = t;
            stop_seen = 1'b1;
            hit       = 1'b1;
          end
          if (hit && hits != 2'd3) hits = hits + 2'd1;
        end else begin
          ph = PH_IDLE;
          if (hits == 2'd2 && start_seen && stop_seen) begin
            v = (longint'(stop_t) - longint'(start_t)) * SCALE;
            if (v > OUT_MAX) v = OUT_MAX;
            if (v < OUT_MIN) v = OUT_MIN;
            got = 1'b1;
            val = v[OUT_W-1:0];
          end
        end
      end
      default: begin
        ph = (hdr == HDR_GLOBAL) ? PH_TDC : PH_IDLE;
      end
    endcase
  endtask

  // Offer one word after a random gap, wait for the beat, then predict.
  task automatic send_word(input logic [WORD_W-1:0] w, input bit known,
                           input logic signed [OUT_W-1:0] typed);
    bit                      got;
    logic signed [OUT_W-1:0] val;
    while (send_idle_pct > $urandom_range(0, 99)) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push        = 1'b1;
    buffer_word = w;
    do @(posedge clk); while (full);
    n_words++;
    parse_word(w, got, val);
    if (known) expect_interval(typed);
    else if (got) expect_interval(val);
  endtask

  // Hold the sender until every predicted interval has come out.
  task automatic wait_drained();
    while (interval_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CH_W-1:0] ch);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = {27'($urandom), ch};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_START) cfg_start = ch;
    else cfg_stop = ch;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic pick_channel(output logic [CH_W-1:0] ch);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) ch = cfg_start;
    else if (r < 8) ch = cfg_stop;
    else ch = 5'($urandom);
  endtask

  // One random event: mostly well formed, some noise and broken headers.
  task automatic send_event();
    int               kind;
    int               n_meas;
    int               r;
    logic [CH_W-1:0]  ch;
    logic [TBITS-1:0] t;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_word($urandom, 1'b0, '0);
    end else if (kind < 18) begin
      send_word(hdr_word(HDR_GLOBAL, 27'($urandom)), 1'b0, '0);
      send_word($urandom, 1'b0, '0);
    end else begin
      send_word(hdr_word(HDR_GLOBAL, 27'($urandom)), 1'b0, '0);
      send_word(hdr_word(HDR_TDC, 27'($urandom)), 1'b0, '0);
      n_meas = ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(0, 4);
      repeat (n_meas) begin
        pick_channel(ch);
        r = $urandom_range(0, 7);
        if (r == 0) t = '0;
        else if (r == 1) t = '1;
        else t = TBITS'($urandom);
        send_word(meas_word(ch, t) | (WORD_W'($urandom_range(0, 1)) << 26), 1'b0, '0);
      end
      send_word(hdr_word(5'($urandom_range(1, 31)), 27'($urandom)), 1'b0, '0);
    end
  endtask

  // Result side: stall at random or for a held stretch, check each beat.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (interval_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected interval %0d at %0t", interval, $realtime);
        end else begin
          n_intervals++;
          if (interval !== interval_q[0]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: interval expected %0d, got %0d at %0t",
                       interval_q[0], interval, $realtime);
          end
          void'(interval_q.pop_front());
        end
      end
    end
  end

  // Stimulus
  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    push           = 1'b0;
    buffer_word    = '0;
    n_words        = 0;
    n_intervals    = 0;
    n_errors       = 0;
    n_settings     = 1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    ph             = PH_IDLE;
    start_t        = '0;
    stop_t         = '0;
    hits           = 2'd0;
    start_seen     = 1'b0;
    stop_seen      = 1'b0;
    cfg_start      = START_CH_RST;
    cfg_stop       = STOP_CH_RST;

    // directed words on the reset channels (start 0, stop 1)
    dir_rows = '{
      '{meas_word(5'd0, 21'd5), 1'b0, '0},              // stray word while idle
      '{hdr_word(HDR_TDC, '0), 1'b0, '0},               // stray TDC header
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},
      '{hdr_word(HDR_TDC, '0), 1'b0, '0},
      '{meas_word(5'd0, 21'd0), 1'b0, '0},
      '{meas_word(5'd1, 21'h1FFFFF), 1'b0, '0},
      '{hdr_word(5'h03, '0), 1'b1, 27'sd52428775},      // largest interval
      '{hdr_word(HDR_GLOBAL, '1), 1'b0, '0},
      '{hdr_word(HDR_TDC, '1), 1'b0, '0},
      '{meas_word(5'd1, 21'd0), 1'b0, '0},
      '{meas_word(5'd7, 21'd12345), 1'b0, '0},          // other channel
      '{meas_word(5'd0, 21'h1FFFFF), 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b1, -27'sd52428775},           // most negative interval
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},            // missing TDC header
      '{hdr_word(HDR_TDC, '0), 1'b0, '0},               // now a stray word
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},
      '{hdr_word(HDR_TDC, '0), 1'b0, '0},
      '{meas_word(5'd0, 21'd100), 1'b0, '0},
      '{meas_word(5'd0, 21'd200), 1'b0, '0},            // repeated start hit
      '{hdr_word(5'h10, '0), 1'b0, '0},                 // two hits, no stop
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},
      '{hdr_word(HDR_TDC, '0), 1'b0, '0},
      '{meas_word(5'd1, 21'd300), 1'b0, '0},
      '{hdr_word(HDR_GLOBAL, '0), 1'b0, '0},            // global header closes
      '{hdr_word(HDR_TDC, '0), 1'b0, '0}                // not a new event
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].interval);

    // random phases, each with its own channel pair and an idling pattern
    for (int p = 0; p < N_PHASES; p++) begin
      int beats0;
      @(negedge clk);
      push = 1'b0;
      wait_drained();
      case (p)
        0: begin
          write_reg(REG_START, 5'd31);
          write_reg(REG_STOP, 5'd0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_START, 5'd5);
          write_reg(REG_STOP, 5'd5);
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_START, 5'd0);
          write_reg(REG_STOP, 5'd31);
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        3: begin
          write_reg(REG_START, 5'($urandom));
          write_reg(REG_STOP, 5'($urandom));
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
        default: begin
          write_reg(REG_START, 5'd31);
          write_reg(REG_STOP, 5'd31);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      n_settings++;
      // hold the result side off long enough to back the block up
      if (p == 0) begin
        @(posedge clk);
        hold_left = LONG_HOLD;
      end
      beats0 = n_words;
      while (n_words - beats0 < PHASE_BEATS) send_event();
    end

    @(negedge clk);
    push = 1'b0;
    wait_drained();
    if (interval_q.size() != 0) n_errors++;

    $display("Run covered %0d buffer words and %0d intervals under %0d channel settings,",
             n_words, n_intervals, n_settings);
    $display("with sender gaps, receiver stalls and a long receiver hold-off.");
    if (n_errors == 0) begin
      $display("PASS tdc_event_start_stop_interval");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL tdc_event_start_stop_interval");
    end
    $finish;
  end

endmodule
